/* rtl/core/riff_wave_stream_parser_defines.svh */
// assertion macros for the riff wave parser rtl
`ifndef RIFF_WAVE_STREAM_PARSER_DEFINES_SVH
`define RIFF_WAVE_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RWP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rwp assertion failed");

// next-cycle implication, checked out of reset
`define RWP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rwp assertion failed");

`endif

/* rtl/core/rwp_pkg.sv */
// package with types and constants of the riff wave stream parser
`timescale 1ns / 1ps
`default_nettype none

package rwp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_FMTX   = 3'd1,
        PH_CHDR   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DONE   = 3'd5
    } rwp_phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_NOT_PCM   = 3'd3;
    localparam logic [2:0] ST_NO_DATA   = 3'd4;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BASE     = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [31:0] MIN_LAST_OFF = 32'd43;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } rwp_in_t;

    typedef struct packed {
        logic        has_sample;
        logic [7:0]  sample;
        logic        done;
        logic [2:0]  status;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] channels;
        logic [31:0] pcm_length;
    } rwp_result_t;

endpackage

`default_nettype wire

/* rtl/core/riff_wave_stream_parser.sv */
// Top level of the RIFF/WAVE stream parser.
// Input channel s_*: one byte of a WAV file per request, s_tlast on the final byte.
// Result channel m_*: one result per PCM data byte (m_tuser high) and one on the
// final byte (m_tlast high, status valid); other bytes give no result.
// Results carry the header values parsed so far and the PCM byte count.
// Status: 0 ok, 1 file shorter than 44 bytes, 2 not RIFF/WAVE, 3 not PCM,
// 4 no data or empty data chunk.
// A byte accepted into the input register passes through the combinational parse
// logic into the result register, whose valid flag drives m_tvalid.
// Throughput: one byte per cycle while m_tready is high; the input register and
// result register hold at most two requests in flight; byte decode is combinational.
// Reset: both registers empty, parser waits for the first header byte.
// Stall: while a result is held unread, the held input byte waits, the input
// register fills and s_tready drops until m_tready returns.
// After the final byte the parser starts over for the next file.
`timescale 1ns / 1ps
`default_nettype none

module riff_wave_stream_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // file_byte
    input  wire logic          s_tlast,   // final_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // sample_byte, status, rate_hz, sample_bits, channel_count, pcm_length, zero pad
    output logic [111:0]       m_tdata,
    output logic               m_tuser,   // has_sample_byte
    output logic               m_tlast    // file_done
);

    logic                 item_valid;
    rwp_pkg::rwp_in_t     item;
    logic                 take;
    logic                 space;
    logic                 res_valid;
    rwp_pkg::rwp_result_t res;

    assign take = item_valid && space;

    rwp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rwp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rwp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_valid),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/core/rwp_in_reg.sv */
// input register of the riff wave parser
`timescale 1ns / 1ps
`default_nettype none

module rwp_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // file_byte
    input  wire logic           s_tlast,   // final_byte
    input  wire logic           take,
    output logic                item_valid,
    output rwp_pkg::rwp_in_t    item
);

    logic             valid_reg;
    logic             valid_next;
    rwp_pkg::rwp_in_t item_reg;

    // a new request may enter when the register is empty or the held byte leaves in this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/core/rwp_parser.sv */
// parse state and per-byte decode of the riff wave parser
`timescale 1ns / 1ps
`default_nettype none
`include "riff_wave_stream_parser_defines.svh"

module rwp_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire rwp_pkg::rwp_in_t    item,
    output logic                     res_valid,
    output rwp_pkg::rwp_result_t     res
);

    rwp_pkg::rwp_phase_t phase_reg, phase_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic [32:0] skip_reg, skip_next;
    logic [31:0] extra_reg, extra_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [1:0]  err_reg, err_next;

    logic [31:0] id_sh;
    logic [31:0] size_sh;
    logic [32:0] skip_dec;
    logic [32:0] skip_inc;
    logic [32:0] chunk_len;
    logic        emit;
    logic [2:0]  status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rwp_pkg::PH_HEADER;
            off_reg   <= '0;
            id_reg    <= '0;
            size_reg  <= '0;
            skip_reg  <= '0;
            extra_reg <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            chan_reg  <= '0;
            cnt_reg   <= '0;
            err_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
            skip_reg  <= skip_next;
            extra_reg <= extra_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        id_sh      = {item.data, id_reg[31:8]};
        size_sh    = {item.data, size_reg[31:8]};
        skip_dec   = (skip_reg != 33'd0) ? (skip_reg - 33'd1) : skip_reg;
        skip_inc   = skip_reg + 33'd1;
        chunk_len  = {1'b0, size_sh} + {32'd0, size_sh[0]};
        phase_next = phase_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        skip_next  = skip_reg;
        extra_next = extra_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        emit       = 1'b0;

        case (phase_reg)
            rwp_pkg::PH_HEADER: begin
                id_next   = id_sh;
                size_next = size_sh;
                if (off_reg == 32'd3 && id_sh != rwp_pkg::ID_RIFF) begin
                    err_next[0] = 1'b1;
                end
                if (off_reg == 32'd11 && id_sh != rwp_pkg::ID_WAVE) begin
                    err_next[0] = 1'b1;
                end
                if (off_reg == 32'd15 && id_sh != rwp_pkg::ID_FMT) begin
                    err_next[1] = 1'b1;
                end
                if (off_reg == 32'd19) begin
                    extra_next = (size_sh > rwp_pkg::FMT_BASE) ?
                                 (size_sh - rwp_pkg::FMT_BASE) : 32'd0;
                end
                if (off_reg == 32'd21 && size_sh[31:16] != rwp_pkg::FMT_PCM) begin
                    err_next[1] = 1'b1;
                end
                if (off_reg == 32'd23) begin
                    chan_next = size_sh[31:16];
                end
                if (off_reg == 32'd27) begin
                    rate_next = size_sh;
                end
                if (off_reg == 32'd35) begin
                    bits_next = size_sh[31:16];
                    if (err_next != 2'd0) begin
                        phase_next = rwp_pkg::PH_DONE;
                    end else if (extra_reg != 32'd0) begin
                        phase_next = rwp_pkg::PH_FMTX;
                        skip_next  = {1'b0, extra_reg};
                    end else begin
                        phase_next = rwp_pkg::PH_CHDR;
                        skip_next  = '0;
                    end
                end
            end
            rwp_pkg::PH_FMTX, rwp_pkg::PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0) begin
                    phase_next = rwp_pkg::PH_CHDR;
                end
            end
            rwp_pkg::PH_CHDR: begin
                // first four bytes are the id, next four the size
                if (skip_reg < 33'd4) begin
                    id_next = id_sh;
                end else begin
                    size_next = size_sh;
                end
                skip_next = skip_inc;
                if (skip_inc == 33'd8) begin
                    if (id_next == rwp_pkg::ID_DATA) begin
                        if (size_next == 32'd0) begin
                            phase_next = rwp_pkg::PH_DONE;
                        end else begin
                            phase_next = rwp_pkg::PH_DATA;
                            skip_next  = {1'b0, size_next};
                        end
                    end else if (chunk_len == 33'd0) begin
                        phase_next = rwp_pkg::PH_CHDR;
                        skip_next  = '0;
                    end else begin
                        phase_next = rwp_pkg::PH_SKIP;
                        skip_next  = chunk_len;
                    end
                end
            end
            rwp_pkg::PH_DATA: begin
                emit      = 1'b1;
                cnt_next  = cnt_reg + 32'd1;
                skip_next = skip_dec;
                if (skip_dec == 33'd0) begin
                    phase_next = rwp_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase

        off_next = (off_reg == 32'hFFFF_FFFF) ? off_reg : (off_reg + 32'd1);

        if (off_reg < rwp_pkg::MIN_LAST_OFF) begin
            status = rwp_pkg::ST_TOO_SHORT;
        end else if (err_next[0]) begin
            status = rwp_pkg::ST_NOT_RIFF;
        end else if (err_next[1]) begin
            status = rwp_pkg::ST_NOT_PCM;
        end else if (cnt_next == 32'd0) begin
            status = rwp_pkg::ST_NO_DATA;
        end else begin
            status = rwp_pkg::ST_OK;
        end

        res_valid      = emit || item.last;
        res.has_sample = emit;
        res.sample     = emit ? item.data : 8'd0;
        res.done       = item.last;
        res.status     = item.last ? status : rwp_pkg::ST_OK;
        res.rate       = rate_next;
        res.bits       = bits_next;
        res.channels   = chan_next;
        res.pcm_length = cnt_next;

        // the final byte returns everything to the start of a new file
        if (item.last) begin
            phase_next = rwp_pkg::PH_HEADER;
            off_next   = '0;
            id_next    = '0;
            size_next  = '0;
            skip_next  = '0;
            extra_next = '0;
            rate_next  = '0;
            bits_next  = '0;
            chan_next  = '0;
            cnt_next   = '0;
            err_next   = '0;
        end
    end

    `RWP_ASSERT_IMP(a_emit_only_in_data, aclk, aresetn,
                    step && res.has_sample, phase_reg == rwp_pkg::PH_DATA)
    `RWP_ASSERT_IMP(a_status_only_on_done, aclk, aresetn,
                    step && res_valid && !res.done, res.status == rwp_pkg::ST_OK)
    `RWP_ASSERT_NEXT(a_restart_after_last, aclk, aresetn, step && item.last,
                     phase_reg == rwp_pkg::PH_HEADER && off_reg == 32'd0 && cnt_reg == 32'd0)

endmodule

`default_nettype wire

/* rtl/core/rwp_out_reg.sv */
// result register of the riff wave parser
`timescale 1ns / 1ps
`default_nettype none

module rwp_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire rwp_pkg::rwp_result_t res,
    output logic                      space,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // sample_byte, status, rate_hz, sample_bits, channel_count, pcm_length, zero pad
    output logic [111:0]              m_tdata,
    output logic                      m_tuser,   // has_sample_byte
    output logic                      m_tlast    // file_done
);

    logic                 valid_reg;
    logic                 valid_next;
    rwp_pkg::rwp_result_t res_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.has_sample;
    assign m_tlast  = res_reg.done;
    assign m_tdata  = {5'd0, res_reg.pcm_length, res_reg.channels, res_reg.bits,
                       res_reg.rate, res_reg.status, res_reg.sample};

endmodule

`default_nettype wire
